/* design/assert_macros.svh */
// assertion macros for the value noise top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

/* design/vn2d_pkg.sv */
// shared constants and helpers for the 2d value noise unit
package vn2d_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;

    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
    localparam logic [23:0] VALUE_MASK   = 24'hffffff;
    localparam int          HASH_SHIFT_A = 13;
    localparam int          HASH_SHIFT_B = 16;

    // 1.0 in q1.16 and 3.0 in q2.16 for the smoothstep
    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [17:0] THREE_Q16 = 18'h30000;

    // truncating linear blend of two 24-bit values by a q0.16 weight
    function automatic logic [23:0] blend(input logic [23:0] p, input logic [23:0] q,
                                          input logic [15:0] s);
        logic [40:0] acc;
        acc = 41'(p) * 41'(ONE_Q16 - 17'(s)) + 41'(q) * 41'(s);
        return acc[39:16];
    endfunction

endpackage

/* design/value_noise_2d_unit.sv */
// top level of the 2d value noise unit with smoothstep fade
//
// usage: drive x_coord and z_coord (signed fixed point, FRAC_BITS fraction
// bits) and raise start for one cycle per request. busy stays low: the
// pipeline takes a new request in every cycle, back to back, with no gaps.
// the result appears on noise_value together with a one-cycle done strobe,
// once the request has passed the input, product, hash, row blend and column
// blend registers; results leave in the order the requests came in, one per request.
// throughput: one request per clock, set by a five-stage register pipeline
// (input register, hash multiplies and fade square, mix multiply and fade
// cubic, row blends, column blend). each stage holds at most one multiply
// level, with adds around it.
// the receiver cannot stall: done is a plain strobe, so nothing is held back.
// reset (rst_n low, asynchronous) clears the valid bits of every stage;
// requests in flight are dropped, and no state survives between requests.
module value_noise_2d_unit #(
    parameter int FRAC_BITS = vn2d_pkg::FRAC_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] x_coord,
    input  logic [31:0] z_coord,
    output logic        done,
    output logic [23:0] noise_value
);
    import vn2d_pkg::*;

    `include "assert_macros.svh"

    // valid bits, one per stage
    logic v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    logic accept;

    // stage 1: captured coordinates
    logic signed [31:0] x1_reg, z1_reg;
    logic [31:0] cx, cz, cx1, cz1;
    logic [15:0] tx, tz;

    // stage 2: lattice products
    logic [31:0] px0_reg, px1_reg, pz0_reg, pz1_reg;

    // stage 3: mixed corner hashes a, b, c, d
    logic [31:0] h_a, h_b, h_c, h_d;
    logic [31:0] hm_a_reg, hm_b_reg, hm_c_reg, hm_d_reg;
    logic [15:0] sx, sz;

    // stage 4: row blends
    logic [23:0] val_a, val_b, val_c, val_d;
    logic [23:0] near_reg, far_reg, near_next, far_next;
    logic [15:0] sz4_reg;

    // stage 5: result
    logic [23:0] noise_reg, noise_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // stage 1: input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x1_reg <= x_coord;
            z1_reg <= z_coord;
        end
    end

    // floor to the lattice cell; the upper neighbor wraps mod 2^32
    assign cx  = 32'(x1_reg >>> FRAC_BITS);
    assign cz  = 32'(z1_reg >>> FRAC_BITS);
    assign cx1 = cx + 32'd1;
    assign cz1 = cz + 32'd1;

    // fraction brought to q0.16
    generate
        if (FRAC_BITS >= 16)
        begin : g_frac_trunc
            assign tx = x1_reg[FRAC_BITS-1 -: 16];
            assign tz = z1_reg[FRAC_BITS-1 -: 16];
        end
        else
        begin : g_frac_pad
            assign tx = {x1_reg[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
            assign tz = {z1_reg[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
        end
    endgenerate

    // stage 2: one multiply per cell coordinate, shared by two corners each
    always_ff @(posedge clk)
    begin
        px0_reg <= 32'(cx  * HASH_MUL_X);
        px1_reg <= 32'(cx1 * HASH_MUL_X);
        pz0_reg <= 32'(cz  * HASH_MUL_Z);
        pz1_reg <= 32'(cz1 * HASH_MUL_Z);
    end

    // fade runs alongside stages 2 and 3
    vn2d_fade u_fade_x (
        .clk (clk),
        .t   (tx),
        .s   (sx)
    );

    vn2d_fade u_fade_z (
        .clk (clk),
        .t   (tz),
        .s   (sz)
    );

    // stage 3: xor-shift then mix multiply
    assign h_a = px0_reg ^ pz0_reg;
    assign h_b = px1_reg ^ pz0_reg;
    assign h_c = px0_reg ^ pz1_reg;
    assign h_d = px1_reg ^ pz1_reg;

    always_ff @(posedge clk)
    begin
        hm_a_reg <= 32'((h_a ^ (h_a >> HASH_SHIFT_A)) * HASH_MUL_MIX);
        hm_b_reg <= 32'((h_b ^ (h_b >> HASH_SHIFT_A)) * HASH_MUL_MIX);
        hm_c_reg <= 32'((h_c ^ (h_c >> HASH_SHIFT_A)) * HASH_MUL_MIX);
        hm_d_reg <= 32'((h_d ^ (h_d >> HASH_SHIFT_A)) * HASH_MUL_MIX);
    end

    // stage 4: corner values and the two row blends along x
    assign val_a = 24'(hm_a_reg ^ (hm_a_reg >> HASH_SHIFT_B)) & VALUE_MASK;
    assign val_b = 24'(hm_b_reg ^ (hm_b_reg >> HASH_SHIFT_B)) & VALUE_MASK;
    assign val_c = 24'(hm_c_reg ^ (hm_c_reg >> HASH_SHIFT_B)) & VALUE_MASK;
    assign val_d = 24'(hm_d_reg ^ (hm_d_reg >> HASH_SHIFT_B)) & VALUE_MASK;

    assign near_next = blend(val_a, val_b, sx);
    assign far_next  = blend(val_c, val_d, sx);

    always_ff @(posedge clk)
    begin
        near_reg <= near_next;
        far_reg  <= far_next;
        sz4_reg  <= sz;
    end

    // stage 5: blend along z
    assign noise_next = blend(near_reg, far_reg, sz4_reg);

    always_ff @(posedge clk)
    begin
        noise_reg <= noise_next;
    end

    assign done        = done_reg;
    assign noise_value = noise_reg;

    // every accepted request comes out once it has passed every stage of the pipeline
    `ASSERT_IMPLIES(a_latency, clk, rst_n, accept, ##5 done)
    // no strobe without a request accepted at the matching earlier edge
    `ASSERT_IMPLIES(a_no_spurious, clk, rst_n, done, $past(accept, 5))
    // a zero z weight passes the near row through unchanged
    `ASSERT_NEXT(a_zero_weight, clk, rst_n, v4_reg && sz4_reg == 16'd0,
                 noise_value == $past(near_reg))

endmodule

/* design/vn2d_fade.sv */
// two-stage smoothstep fade 3t^2 - 2t^3 in q0.16
module vn2d_fade (
    input  logic        clk,
    input  logic [15:0] t,
    output logic [15:0] s
);
    import vn2d_pkg::*;

    logic [31:0] t2_reg;
    logic [15:0] t_reg;
    logic [17:0] slope;
    logic [33:0] prod;
    logic [15:0] s_reg;

    // stage a: square
    always_ff @(posedge clk)
    begin
        t2_reg <= 32'(t) * 32'(t);
        t_reg  <= t;
    end

    // stage b: floor(t^2) times (3 - 2t)
    assign slope = THREE_Q16 - {1'b0, t_reg, 1'b0};
    assign prod  = 34'(t2_reg[31:16]) * 34'(slope);

    always_ff @(posedge clk)
    begin
        s_reg <= prod[31:16];
    end

    assign s = s_reg;

endmodule

/* verif/value_noise_2d_unit_tb.sv */
// testbench for the 2d value noise unit: random and corner-case requests against a predictor
`timescale 1ns / 1ps

module value_noise_2d_unit_tb;

    localparam int FRAC_BITS = 16;

    // lattice hash and fade constants, as the noise definition gives them
    localparam bit [31:0] LATTICE_MUL_X   = 32'd374761393;
    localparam bit [31:0] LATTICE_MUL_Z   = 32'd668265263;
    localparam bit [31:0] LATTICE_MUL_MIX = 32'd1274126177;
    localparam bit [63:0] UNIT_Q16        = 64'd65536;

    localparam int N_DIRECTED   = 18;
    localparam int N_PER_PHASE  = 650;
    localparam int SETTLE_TICKS = 12;

    // scoreboard: predicts the noise of every accepted request and checks results in order
    class noise_scoreboard;
        bit [23:0]   pending_noise[$];
        int unsigned errors;

        // floor of a fixed-point coordinate, as a 32-bit lattice cell
        function bit [31:0] lattice_cell(bit [31:0] v);
            return {{FRAC_BITS{v[31]}}, v[31:FRAC_BITS]};
        endfunction

        // 24-bit corner value of one lattice point, all products wrap at 32 bits
        function bit [23:0] corner_hash(bit [31:0] cx, bit [31:0] cz);
            bit [31:0] h;
            h = (cx * LATTICE_MUL_X) ^ (cz * LATTICE_MUL_Z);
            h = (h ^ (h >> 13)) * LATTICE_MUL_MIX;
            h = h ^ (h >> 16);
            return h[23:0];
        endfunction

        // smoothstep weight in q0.16 from the fraction bits of a coordinate
        function bit [63:0] fade_weight(bit [31:0] v);
            bit [63:0] t;
            bit [63:0] t2;
            t = 64'(v & ((32'd1 << FRAC_BITS) - 32'd1));
            if (FRAC_BITS >= 16)
                t = t >> (FRAC_BITS - 16);
            else
                t = t << (16 - FRAC_BITS);
            t  = t & 64'hffff;
            t2 = (t * t) >> 16;
            return (t2 * (3 * UNIT_Q16 - 2 * t)) >> 16;
        endfunction

        // truncating linear blend by a q0.16 weight
        function bit [63:0] lerp_q16(bit [63:0] p, bit [63:0] q, bit [63:0] s);
            return (p * (UNIT_Q16 - s) + q * s) >> 16;
        endfunction

        function void note_request(bit [31:0] x, bit [31:0] z);
            bit [31:0] cx0, cz0, cx1, cz1;
            bit [63:0] sx, sz, near_row, far_row, mixed;
            cx0 = lattice_cell(x);
            cz0 = lattice_cell(z);
            cx1 = cx0 + 32'd1;
            cz1 = cz0 + 32'd1;
            sx  = fade_weight(x);
            sz  = fade_weight(z);
            near_row = lerp_q16(64'(corner_hash(cx0, cz0)), 64'(corner_hash(cx1, cz0)), sx);
            far_row  = lerp_q16(64'(corner_hash(cx0, cz1)), 64'(corner_hash(cx1, cz1)), sx);
            mixed    = lerp_q16(near_row, far_row, sz);
            pending_noise.push_back(mixed[23:0]);
        endfunction

        function void check_noise(logic [23:0] actual);
            bit [23:0] want;
            if (pending_noise.size() == 0)
            begin
                $display("%0t: noise result with no request pending, expected none, actual %h",
                         $time, actual);
                errors++;
            end
            else
            begin
                want = pending_noise.pop_front();
                if (actual !== want)
                begin
                    $display("%0t: noise_value mismatch, expected %h, actual %h",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] x_coord;
    logic [31:0] z_coord;
    logic        done;
    logic [23:0] noise_value;

    noise_scoreboard sb;

    // corner cases: range extremes, cell wrap at minus one, fraction edges, bit patterns
    bit [31:0] directed_x [N_DIRECTED] = '{
        32'h00000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff,
        32'hffff0000, 32'h0000ffff, 32'h00008000, 32'h00000001, 32'h00010000, 32'h7fff0000,
        32'h8000ffff, 32'h00000000, 32'hffff8000, 32'h12345678, 32'haaaaaaaa, 32'h55555555
    };
    bit [31:0] directed_z [N_DIRECTED] = '{
        32'h00000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffffffff,
        32'h00000000, 32'h0000ffff, 32'h00008000, 32'h00000001, 32'hffff0000, 32'h7fffffff,
        32'h00000000, 32'h8000ffff, 32'h00018000, 32'h9abcdef0, 32'h55555555, 32'haaaaaaaa
    };

    value_noise_2d_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_coord    (x_coord),
        .z_coord    (z_coord),
        .done       (done),
        .noise_value(noise_value)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // monitor: outputs are sampled at the edge before the design updates them,
    // so a request counts when start was high and busy low at that edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // note the request before checking, so a short pipeline still lines up
            if (start && busy === 1'b0)
                sb.note_request(x_coord, z_coord);
            if (done)
                sb.check_noise(noise_value);
        end
    end

    // coordinate generator: full range, small cells around the origin, and fraction edges
    function automatic bit [31:0] random_coord();
        bit [31:0] v;
        bit [15:0] frac;
        case ($urandom_range(3))
            0: v = $urandom;
            1:
            begin
                // cells from -8 to 7 with any fraction
                v = (32'($urandom_range(15)) - 32'd8) << 16;
                v[15:0] = 16'($urandom);
            end
            2:
            begin
                case ($urandom_range(4))
                    0: frac = 16'h0000;
                    1: frac = 16'h0001;
                    2: frac = 16'hffff;
                    3: frac = 16'h8000;
                    default: frac = 16'($urandom);
                endcase
                v = {16'($urandom), frac};
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // hold one request on the ports until an edge takes it
    task automatic send_request(bit [31:0] x, bit [31:0] z);
        start   <= 1'b1;
        x_coord <= x;
        z_coord <= z;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // sender idles in idle_pct cycles of a hundred; the ports carry junk while start is low
    task automatic sender_gap(int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start   <= 1'b0;
            x_coord <= $urandom;
            z_coord <= $urandom;
            @(posedge clk);
        end
    endtask

    // stop sending until every predicted result has come back; the first edge
    // lets the monitor note the request taken at the edge just passed
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_noise.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_phase(int unsigned idle_pct);
        repeat (N_PER_PHASE)
        begin
            send_request(random_coord(), random_coord());
            sender_gap(idle_pct);
        end
        drain_pipeline();
    endtask

    // main sequence
    initial
    begin
        sb      = new();
        rst_n   = 1'b0;
        start   = 1'b0;
        x_coord = '0;
        z_coord = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner cases back to back
        for (int i = 0; i < N_DIRECTED; i++)
            send_request(directed_x[i], directed_z[i]);
        drain_pipeline();

        // random phases: light idling, heavy idling, then a full-rate stream
        run_random_phase(27);
        run_random_phase(64);
        run_random_phase(0);

        // let any stray strobe show up
        repeat (SETTLE_TICKS) @(posedge clk);

        if (sb.errors == 0 && sb.pending_noise.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, far above the slowest correct run
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
